// ===== sv/ilist_pkg.sv =====
// ----------------------------------------------------------------------------
// ilist_pkg
// shared widths, command codes, status codes and control structs for the
// positional list block
// ----------------------------------------------------------------------------
package ilist_pkg;

   localparam int CAPACITY_DEF = 32;

   localparam int KIND_W    = 3;
   localparam int POS_W     = 6;
   localparam int VAL_W     = 32;
   localparam int STAT_W    = 2;
   localparam int LEN_OUT_W = 6;

   // command kinds
   localparam logic [KIND_W-1:0] KIND_GET      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ADD_HEAD = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ADD_TAIL = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ADD_POS  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DEL_POS  = 3'd4;

   // result status codes
   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture accepted request
      logic get_read;   // read entry at position
      logic shift;      // read one entry of the shift, write it back next cycle
      logic write_val;  // store the new value at position
      logic finish;     // update length and load the response register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_get;
      logic is_ins;
      logic is_del;
      logic get_ok;
      logic ins_ok;
      logic del_ok;
      logic no_shift;
      logic shift_last;
      logic rsp_free;
   } stat_type;

endpackage

// ===== sv/ilist_ram.sv =====
// ----------------------------------------------------------------------------
// ilist_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ilist_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/ilist_ctrl.sv =====
// ----------------------------------------------------------------------------
// ilist_ctrl
// command sequencer: decode, shift loop, value write and response hand-off
// ----------------------------------------------------------------------------
module ilist_ctrl
   import ilist_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SHIFT,
      S_DRAIN,
      S_WRVAL,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            priority if (stat.is_get) begin
               cmd.get_read = stat.get_ok;
               state_in     = S_FINISH;
            end else if (stat.is_ins && stat.ins_ok) begin
               state_in = stat.no_shift ? S_WRVAL : S_SHIFT;
            end else if (stat.is_del && stat.del_ok) begin
               state_in = stat.no_shift ? S_FINISH : S_SHIFT;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (stat.shift_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // last shifted entry is written this cycle
            state_in = stat.is_ins ? S_WRVAL : S_FINISH;
         end
         S_WRVAL: begin
            cmd.write_val = 1'b1;
            state_in      = S_FINISH;
         end
         S_FINISH: begin
            if (stat.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == S_IDLE);
      end
   end

   assign req_ready = req_ready_ff;

endmodule

// ===== sv/ilist_dp.sv =====
// ----------------------------------------------------------------------------
// ilist_dp
// list datapath: command registers, length, shift index, value ram and
// response register
// ----------------------------------------------------------------------------
module ilist_dp
   import ilist_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cmd_type                     cmd,
   output stat_type                    stat,
   input  logic [KIND_W-1:0]           req_kind,
   input  logic [POS_W-1:0]            req_position,
   input  logic signed [VAL_W-1:0]     req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [VAL_W-1:0]     rsp_read_value,
   output logic                        rsp_found,
   output logic [STAT_W-1:0]           rsp_status,
   output logic [LEN_OUT_W-1:0]        rsp_length
);

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int LEN_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (LEN_W > POS_W) ? LEN_W : POS_W;
   localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(CAPACITY);

   logic [KIND_W-1:0]       kind_ff;
   logic [CMP_W-1:0]        pos_ff, pos_in;
   logic signed [VAL_W-1:0] val_ff;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic [LEN_W-1:0]        idx_ff, idx_in;
   logic                    wr_pend_ff;
   logic [ADDR_W-1:0]       wr_addr_ff, wr_addr_in;

   logic                    rsp_valid_ff;
   logic signed [VAL_W-1:0] rd_val_ff, rd_val_in;
   logic                    found_ff, found_in;
   logic [STAT_W-1:0]       status_ff, status_in;
   logic [LEN_OUT_W-1:0]    len_out_ff;

   logic [CMP_W-1:0]        len_ext, idx_ext, len_new_ext;
   logic [CMP_W:0]          req_pos_inc, pos_inc;
   logic                    is_get, is_ins, is_del;
   logic                    get_ok, ins_ok, del_ok, full;

   logic                    ram_we, ram_re;
   logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
   logic [VAL_W-1:0]        ram_wdata, ram_rdata;

   assign len_ext     = CMP_W'(len_ff);
   assign idx_ext     = CMP_W'(idx_ff);
   assign req_pos_inc = {1'b0, CMP_W'(req_position)} + 1'b1;
   assign pos_inc     = {1'b0, pos_ff} + 1'b1;

   assign is_get = (kind_ff == KIND_GET);
   assign is_ins = (kind_ff == KIND_ADD_HEAD) || (kind_ff == KIND_ADD_TAIL) ||
                   (kind_ff == KIND_ADD_POS);
   assign is_del = (kind_ff == KIND_DEL_POS);
   assign full   = (len_ff == LEN_FULL);
   assign get_ok = (pos_ff < len_ext);
   assign del_ok = get_ok;
   assign ins_ok = (pos_ff <= len_ext) && !full;

   always_comb begin
      stat          = '0;
      stat.is_get   = is_get;
      stat.is_ins   = is_ins;
      stat.is_del   = is_del;
      stat.get_ok   = get_ok;
      stat.ins_ok   = ins_ok;
      stat.del_ok   = del_ok;
      stat.rsp_free = !rsp_valid_ff || rsp_ready;
      if (is_ins) begin
         stat.no_shift   = (pos_ff == len_ext);
         stat.shift_last = (idx_ext == pos_ff);
      end else begin
         stat.no_shift   = (pos_inc == {1'b0, len_ext});
         stat.shift_last = (idx_ff == len_ff - 1'b1);
      end
   end

   // request capture, effective position, first shift index and its step during the shift
   always_comb begin
      unique case (req_kind)
         KIND_ADD_HEAD: pos_in = '0;
         KIND_ADD_TAIL: pos_in = len_ext;
         default:       pos_in = CMP_W'(req_position);
      endcase
      if (req_kind == KIND_DEL_POS) begin
         idx_in = req_pos_inc[LEN_W-1:0];
      end else begin
         idx_in = len_ff - 1'b1;
      end
      if (cmd.shift) begin
         idx_in = is_ins ? (idx_ff - 1'b1) : (idx_ff + 1'b1);
      end else if (!cmd.load) begin
         idx_in = idx_ff;
      end
   end

   // shift write-back destination, one above on insert, one below on delete
   always_comb begin
      if (is_ins) begin
         wr_addr_in = ADDR_W'(idx_ff + 1'b1);
      end else begin
         wr_addr_in = ADDR_W'(idx_ff - 1'b1);
      end
   end

   // ram port selection
   always_comb begin
      ram_re    = cmd.shift || cmd.get_read;
      ram_raddr = cmd.shift ? idx_ff[ADDR_W-1:0] : pos_ff[ADDR_W-1:0];
      ram_we    = wr_pend_ff || cmd.write_val;
      ram_waddr = wr_pend_ff ? wr_addr_ff : pos_ff[ADDR_W-1:0];
      ram_wdata = wr_pend_ff ? ram_rdata : val_ff;
   end

   // response fields and new length
   always_comb begin
      rd_val_in = '0;
      found_in  = 1'b0;
      status_in = ST_DONE;
      len_in    = len_ff;
      unique case (kind_ff)
         KIND_GET: begin
            if (get_ok) begin
               rd_val_in = ram_rdata;
               found_in  = 1'b1;
            end else begin
               rd_val_in = -1;
               status_in = ST_RANGE;
            end
         end
         KIND_ADD_HEAD, KIND_ADD_TAIL, KIND_ADD_POS: begin
            priority if (pos_ff > len_ext) begin
               status_in = ST_RANGE;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               len_in = len_ff + 1'b1;
            end
         end
         KIND_DEL_POS: begin
            if (del_ok) begin
               len_in = len_ff - 1'b1;
            end else begin
               status_in = ST_RANGE;
            end
         end
         default: begin
            len_in = len_ff;
         end
      endcase
      len_new_ext = CMP_W'(len_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_pend_ff <= cmd.shift;
         if (cmd.finish) begin
            len_ff       <= len_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         pos_ff  <= pos_in;
         val_ff  <= req_value;
      end
      idx_ff <= idx_in;
      if (cmd.shift) begin
         wr_addr_ff <= wr_addr_in;
      end
      if (cmd.finish) begin
         rd_val_ff  <= rd_val_in;
         found_ff   <= found_in;
         status_ff  <= status_in;
         len_out_ff <= len_new_ext[LEN_OUT_W-1:0];
      end
   end

   ilist_ram #(
      .WIDTH (VAL_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rd_val_ff;
   assign rsp_found      = found_ff;
   assign rsp_status     = status_ff;
   assign rsp_length     = len_out_ff;

endmodule

// ===== sv/indexed_list_insert_delete_get_top.sv =====
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_get_top
// ordered list of signed 32-bit values with get, insert and delete by
// position, held in a ram with a length counter
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  req_      in         req_valid / req_ready  kind, position, value
//  rsp_      out        rsp_valid / rsp_ready  read_value, found, status, length
//
//  one request at a time; a get, an unused kind or a rejected request goes
//  from decode to finish, an insert that shifts runs the shift loop, drain
//  and value write, an append only the value write, a delete that shifts
//  the loop and drain, a delete of the last entry straight to finish; the shift
//  loop moves one ram entry per cycle, and req_ready comes back with rsp_valid
//  reset is synchronous and empties the list; ram contents are not cleared
//  a waiting response does not block the next accept; a second finished
//  request holds in the controller until the response register frees up
//
module indexed_list_insert_delete_get_top
   import ilist_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [KIND_W-1:0]       req_kind,
   input  logic [POS_W-1:0]        req_position,
   input  logic signed [VAL_W-1:0] req_value,
   // response channel
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [VAL_W-1:0] rsp_read_value,
   output logic                    rsp_found,
   output logic [STAT_W-1:0]       rsp_status,
   output logic [LEN_OUT_W-1:0]    rsp_length
);

   // command and status between sequencer and datapath
   cmd_type  cmd;
   stat_type stat;

   // sequencer: accepts a request only when idle, walks the shift loop
   ilist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: list ram, length, shift index and response register
   ilist_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_kind       (req_kind),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_value (rsp_read_value),
      .rsp_found      (rsp_found),
      .rsp_status     (rsp_status),
      .rsp_length     (rsp_length)
   );

endmodule

// ===== sv/ilist_checker.sv =====
// ----------------------------------------------------------------------------
// ilist_checker
// port level checks on the response channel of the positional list block
// ----------------------------------------------------------------------------
module ilist_checker
   import ilist_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [VAL_W-1:0] rsp_read_value,
   input logic                    rsp_found,
   input logic [STAT_W-1:0]       rsp_status,
   input logic [LEN_OUT_W-1:0]    rsp_length
);

   localparam logic [LEN_OUT_W-1:0] CAP_LEN = LEN_OUT_W'(CAPACITY);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value) &&
      $stable(rsp_found) && $stable(rsp_status) && $stable(rsp_length))
      else $error("stalled response changed");

   // a hit is always a clean completion
   a_found_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == ST_DONE)
      else $error("found with non-done status");

   // full drop only happens at capacity
   a_full_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_length == CAP_LEN)
      else $error("full status below capacity");

   // no status code beyond the defined ones
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_FULL)
      else $error("undefined status code");

   // reset drops any pending response
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind indexed_list_insert_delete_get_top ilist_checker #(
   .CAPACITY (CAPACITY)
) u_ilist_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the positional list block: drives get, insert,
// delete and unused-kind requests, predicts each response from a shadow list
// or a pinned table row, checks it field by field under sender/receiver idling
// ----------------------------------------------------------------------------
module tb;
   import ilist_pkg::*;

   localparam int LIST_CAP    = CAPACITY_DEF;
   localparam int IDLE_LIMIT  = 3000;  // cycles with no handshake before giving up
   localparam int MAX_REPORTS = 40;    // cap on printed mismatch lines
   localparam int HOLD_OFF    = 300;   // long receiver stall for the back-pressure phase

   localparam logic signed [VAL_W-1:0] MINUS_ONE = -32'sd1;
   localparam logic signed [VAL_W-1:0] VAL_MAX   = 32'sh7fffffff;
   localparam logic signed [VAL_W-1:0] VAL_MIN   = 32'sh80000000;

   // one response as seen on the rsp_ channel
   typedef struct packed {
      logic signed [VAL_W-1:0] read_value;
      logic                    found;
      logic [STAT_W-1:0]       status;
      logic [LEN_OUT_W-1:0]    length;
   } list_rsp_type;

   // one directed request; want is used only when pinned is set
   typedef struct packed {
      logic [KIND_W-1:0]       kind;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] value;
      logic                    pinned;
      list_rsp_type            want;
   } dir_row_type;

   localparam list_rsp_type FROM_MODEL = '0;

   // directed table: empty list, extremes of position and value, every kind,
   // unused kind codes, out-of-range get, insert and delete, append by index
   localparam int N_DIR = 25;
   localparam dir_row_type DIRECTED [N_DIR] = '{
      // empty list: get, delete and insert past the end are all out of range
      '{KIND_GET,      6'd0,  32'sd0,         1'b1, '{MINUS_ONE, 1'b0, ST_RANGE, 6'd0}},
      '{KIND_DEL_POS,  6'd0,  32'sd0,         1'b1, '{32'sd0,    1'b0, ST_RANGE, 6'd0}},
      '{KIND_ADD_POS,  6'd1,  32'sd77,        1'b1, '{32'sd0,    1'b0, ST_RANGE, 6'd0}},
      '{KIND_GET,      6'd63, 32'sd0,         1'b1, '{MINUS_ONE, 1'b0, ST_RANGE, 6'd0}},
      // build [max, -1, min, 0]
      '{KIND_ADD_HEAD, 6'd63, VAL_MAX,        1'b1, '{32'sd0,    1'b0, ST_DONE,  6'd1}},
      '{KIND_ADD_TAIL, 6'd0,  VAL_MIN,        1'b1, '{32'sd0,    1'b0, ST_DONE,  6'd2}},
      '{KIND_ADD_POS,  6'd1,  MINUS_ONE,      1'b1, '{32'sd0,    1'b0, ST_DONE,  6'd3}},
      // position equal to length appends
      '{KIND_ADD_POS,  6'd3,  32'sd0,         1'b1, '{32'sd0,    1'b0, ST_DONE,  6'd4}},
      '{KIND_ADD_POS,  6'd5,  32'sd1234,      1'b1, '{32'sd0,    1'b0, ST_RANGE, 6'd4}},
      '{KIND_ADD_POS,  6'd63, 32'sh5a5a5a5a,  1'b1, '{32'sd0,    1'b0, ST_RANGE, 6'd4}},
      '{KIND_GET,      6'd0,  32'sd0,         1'b0, FROM_MODEL},
      '{KIND_GET,      6'd1,  32'sd0,         1'b0, FROM_MODEL},
      '{KIND_GET,      6'd2,  32'sd0,         1'b0, FROM_MODEL},
      '{KIND_GET,      6'd3,  32'sd0,         1'b0, FROM_MODEL},
      '{KIND_GET,      6'd4,  32'sd0,         1'b1, '{MINUS_ONE, 1'b0, ST_RANGE, 6'd4}},
      // unused kind codes leave the list alone
      '{3'd5,          6'd63, 32'sha5a5a5a5,  1'b1, '{32'sd0,    1'b0, ST_DONE,  6'd4}},
      '{3'd6,          6'd21, 32'sd1,         1'b1, '{32'sd0,    1'b0, ST_DONE,  6'd4}},
      '{3'd7,          6'd42, VAL_MIN,        1'b1, '{32'sd0,    1'b0, ST_DONE,  6'd4}},
      '{KIND_DEL_POS,  6'd4,  32'sd0,         1'b1, '{32'sd0,    1'b0, ST_RANGE, 6'd4}},
      '{KIND_DEL_POS,  6'd63, 32'sd0,         1'b1, '{32'sd0,    1'b0, ST_RANGE, 6'd4}},
      // delete the head, then the tail
      '{KIND_DEL_POS,  6'd0,  32'sd0,         1'b0, FROM_MODEL},
      '{KIND_DEL_POS,  6'd2,  32'sd0,         1'b0, FROM_MODEL},
      '{KIND_GET,      6'd0,  32'sd0,         1'b0, FROM_MODEL},
      '{KIND_GET,      6'd1,  32'sd0,         1'b0, FROM_MODEL},
      '{KIND_ADD_HEAD, 6'd0,  32'sd0,         1'b0, FROM_MODEL}
   };

   // dut inputs, all known from time zero
   logic                    clock        = 1'b0;
   logic                    reset        = 1'b1;
   logic                    req_valid    = 1'b0;
   logic                    req_ready;
   logic [KIND_W-1:0]       req_kind     = '0;
   logic [POS_W-1:0]        req_position = '0;
   logic signed [VAL_W-1:0] req_value    = '0;
   logic                    rsp_valid;
   logic                    rsp_ready    = 1'b0;
   logic signed [VAL_W-1:0] rsp_read_value;
   logic                    rsp_found;
   logic [STAT_W-1:0]       rsp_status;
   logic [LEN_OUT_W-1:0]    rsp_length;

   // shadow copy of the list that the prediction works on
   logic signed [VAL_W-1:0] list_shadow [LIST_CAP];
   int                      shadow_len = 0;

   // responses still owed by the block, oldest first
   list_rsp_type            pending_rsps [$];

   // idling knobs, percent per cycle
   int send_idle_pct   = 0;
   int rsp_stall_pct   = 0;
   int hold_off_req    = 0;   // set by the main sequence, taken by the ready process
   int hold_off_left   = 0;

   // bookkeeping
   int n_errors    = 0;
   int n_requests  = 0;
   int n_responses = 0;
   int n_found     = 0;
   int n_range     = 0;
   int n_full      = 0;
   int idle_cycles = 0;

   indexed_list_insert_delete_get_top #(
      .CAPACITY (LIST_CAP)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_value (rsp_read_value),
      .rsp_found      (rsp_found),
      .rsp_status     (rsp_status),
      .rsp_length     (rsp_length)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // apply one request to the shadow list and return the response it owes
   function automatic list_rsp_type apply_list_cmd(input logic [KIND_W-1:0] kind,
                                                   input logic [POS_W-1:0] position,
                                                   input logic signed [VAL_W-1:0] value);
      list_rsp_type r;
      int           at;
      r = '0;
      r.status = ST_DONE;
      case (kind)
         KIND_GET: begin
            if (int'(position) < shadow_len) begin
               r.read_value = list_shadow[position];
               r.found      = 1'b1;
            end else begin
               r.read_value = MINUS_ONE;
               r.status     = ST_RANGE;
            end
         end
         KIND_ADD_HEAD, KIND_ADD_TAIL, KIND_ADD_POS: begin
            // head and tail ignore the position field
            if (kind == KIND_ADD_HEAD)
               at = 0;
            else if (kind == KIND_ADD_TAIL)
               at = shadow_len;
            else
               at = int'(position);
            // range is judged before fullness
            if (at > shadow_len)
               r.status = ST_RANGE;
            else if (shadow_len >= LIST_CAP)
               r.status = ST_FULL;
            else begin
               for (int i = shadow_len; i > at; i--)
                  list_shadow[i] = list_shadow[i-1];
               list_shadow[at] = value;
               shadow_len++;
            end
         end
         KIND_DEL_POS: begin
            if (int'(position) < shadow_len) begin
               for (int i = int'(position); i + 1 < shadow_len; i++)
                  list_shadow[i] = list_shadow[i+1];
               shadow_len--;
            end else
               r.status = ST_RANGE;
         end
         default: ;  // unused codes: nothing changes
      endcase
      r.length = shadow_len[LEN_OUT_W-1:0];
      return r;
   endfunction

   // offer one request; entered and left at a falling edge. valid stays high
   // across back-to-back requests and is only lowered for an idle gap
   task automatic send_request(input logic [KIND_W-1:0] kind,
                               input logic [POS_W-1:0] position,
                               input logic signed [VAL_W-1:0] value,
                               input logic pinned,
                               input list_rsp_type pinned_rsp);
      int           gap;
      list_rsp_type predicted;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_position <= position;
      req_value    <= value;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      // accepted at this edge
      predicted = apply_list_cmd(kind, position, value);
      pending_rsps.push_back(pinned ? pinned_rsp : predicted);
      n_requests++;
      @(negedge clock);
   endtask

   // data values lean toward the extremes now and then
   function automatic logic signed [VAL_W-1:0] pick_value();
      case ($urandom_range(15))
         0:       return VAL_MAX;
         1:       return VAL_MIN;
         2:       return MINUS_ONE;
         3:       return 32'sd0;
         default: return $urandom;
      endcase
   endfunction

   // a valid position in the current list, or any position on an empty one
   function automatic logic [POS_W-1:0] pick_live_pos();
      if (shadow_len > 0)
         return POS_W'($urandom_range(shadow_len - 1));
      return POS_W'($urandom_range(63));
   endfunction

   task automatic send_random_cmd();
      int                      sel;
      logic [KIND_W-1:0]       kind;
      logic [POS_W-1:0]        position;
      sel      = $urandom_range(99);
      position = POS_W'($urandom_range(63));
      if (sel < 14) begin
         kind     = KIND_GET;
         position = pick_live_pos();
      end else if (sel < 20)
         kind = KIND_GET;
      else if (sel < 30)
         kind = KIND_ADD_HEAD;
      else if (sel < 40)
         kind = KIND_ADD_TAIL;
      else if (sel < 58) begin
         kind     = KIND_ADD_POS;
         position = POS_W'($urandom_range(shadow_len));
      end else if (sel < 62)
         kind = KIND_ADD_POS;
      else if (sel < 86) begin
         kind     = KIND_DEL_POS;
         position = pick_live_pos();
      end else if (sel < 92)
         kind = KIND_DEL_POS;
      else
         kind = KIND_W'($urandom_range(5, 7));
      send_request(kind, position, pick_value(), 1'b0, FROM_MODEL);
   endtask

   // insert until full, then poke the full list: in-range adds are dropped,
   // adds past the end report range first, then read a few entries back
   task automatic fill_run();
      while (shadow_len < LIST_CAP) begin
         case ($urandom_range(2))
            0:       send_request(KIND_ADD_HEAD, POS_W'($urandom_range(63)), pick_value(),
                                  1'b0, FROM_MODEL);
            1:       send_request(KIND_ADD_TAIL, POS_W'($urandom_range(63)), pick_value(),
                                  1'b0, FROM_MODEL);
            default: send_request(KIND_ADD_POS, POS_W'($urandom_range(shadow_len)),
                                  pick_value(), 1'b0, FROM_MODEL);
         endcase
      end
      send_request(KIND_ADD_TAIL, 6'd0, pick_value(), 1'b0, FROM_MODEL);
      send_request(KIND_ADD_HEAD, 6'd63, pick_value(), 1'b0, FROM_MODEL);
      send_request(KIND_ADD_POS, POS_W'($urandom_range(LIST_CAP)), pick_value(),
                   1'b0, FROM_MODEL);
      send_request(KIND_ADD_POS, POS_W'($urandom_range(LIST_CAP + 1, 63)), pick_value(),
                   1'b0, FROM_MODEL);
      send_request(KIND_GET, POS_W'(LIST_CAP - 1), 32'sd0, 1'b0, FROM_MODEL);
      send_request(KIND_GET, POS_W'(LIST_CAP), 32'sd0, 1'b0, FROM_MODEL);
      send_request(KIND_GET, pick_live_pos(), 32'sd0, 1'b0, FROM_MODEL);
   endtask

   // delete until empty, then try the empty list
   task automatic drain_run();
      while (shadow_len > 0)
         send_request(KIND_DEL_POS, pick_live_pos(), pick_value(), 1'b0, FROM_MODEL);
      send_request(KIND_DEL_POS, 6'd0, 32'sd0, 1'b0, FROM_MODEL);
      send_request(KIND_GET, 6'd0, 32'sd0, 1'b0, FROM_MODEL);
   endtask

   task automatic run_random(input int count);
      int stop_at;
      int sel;
      stop_at = n_requests + count;
      while (n_requests < stop_at) begin
         sel = $urandom_range(99);
         if (sel < 2)
            fill_run();
         else if (sel < 4)
            drain_run();
         else
            send_random_cmd();
      end
   endtask

   // sender stays quiet until every owed response has arrived
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_rsps.size() != 0)
         @(negedge clock);
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      n_errors++;
      if (n_errors <= MAX_REPORTS)
         $display("mismatch on response %0d, %s: got %0h, want %0h",
                  n_responses, field, got, want);
   endtask

   // receiver: random stalls, plus a long hold-off counted here on request
   always @(negedge clock) begin
      if (hold_off_req > 0) begin
         hold_off_left = hold_off_req;
         hold_off_req  = 0;
      end
      if (hold_off_left > 0) begin
         hold_off_left = hold_off_left - 1;
         rsp_ready <= 1'b0;
      end else
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // response checker: each accepted response against the oldest expectation
   always @(posedge clock) begin : check_rsp
      list_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         n_responses++;
         if (pending_rsps.size() == 0) begin
            n_errors++;
            $display("unexpected response %0d with nothing outstanding", n_responses);
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_read_value !== want.read_value)
               report_mismatch("read_value", rsp_read_value, want.read_value);
            if (rsp_found !== want.found)
               report_mismatch("found", 32'(rsp_found), 32'(want.found));
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
            if (rsp_length !== want.length)
               report_mismatch("length", 32'(rsp_length), 32'(want.length));
            if (want.found)
               n_found++;
            if (want.status == ST_RANGE)
               n_range++;
            if (want.status == ST_FULL)
               n_full++;
         end
      end
   end

   // watchdog: too long without any handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
                  idle_cycles, pending_rsps.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin : main_seq
      int leftover;

      // reset held from time zero, released at a falling edge
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table, no idling
      for (int i = 0; i < N_DIR; i++)
         send_request(DIRECTED[i].kind, DIRECTED[i].position, DIRECTED[i].value,
                      DIRECTED[i].pinned, DIRECTED[i].want);

      // make sure the full list and the empty list are both reached
      fill_run();
      drain_run();
      wait_for_drain();

      // random traffic under each idling mix
      run_random(160);
      wait_for_drain();

      send_idle_pct = 48;
      rsp_stall_pct = 0;
      run_random(150);
      wait_for_drain();

      send_idle_pct = 0;
      rsp_stall_pct = 48;
      run_random(150);
      wait_for_drain();

      send_idle_pct = 30;
      rsp_stall_pct = 30;
      run_random(150);
      wait_for_drain();

      // back-pressure: receiver holds off while the sender keeps pushing,
      // so the response register and the controller both fill and req_ready drops
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_off_req  = HOLD_OFF;
      run_random(20);
      wait_for_drain();

      // settle, then check nothing is left owed
      repeat (50) @(posedge clock);
      leftover = pending_rsps.size();
      if (leftover != 0) begin
         n_errors += leftover;
         $display("%0d responses never arrived", leftover);
      end

      $display("covered %0d requests and %0d responses under four idling mixes plus a",
               n_requests, n_responses);
      $display("long stall: %0d hits, %0d out-of-range, %0d dropped on a full list, %0d errors",
               n_found, n_range, n_full, n_errors);
      if (n_errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
